[design/tcc_pkg.sv]
// tetrahedron circumcenter: shared widths, status codes and payload types
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps
`default_nettype none

package tcc_pkg;

  localparam int COORD_WIDTH  = 32;
  localparam int THRESH_WIDTH = 49;
  localparam logic [THRESH_WIDTH-1:0] THRESH_RESET = THRESH_WIDTH'(1);

  // limb size of the split multipliers
  localparam int LIMB = 32;

  localparam int EW   = COORD_WIDTH + 1;   // edge vector component
  localparam int PW   = 2 * EW;            // edge product
  localparam int CW   = PW + 1;            // cross product component
  localparam int NRMW = PW + 2;            // squared edge length
  localparam int DW   = EW + CW + 2;       // orientation determinant
  localparam int DENW = DW + 1;            // 2 |det|
  localparam int PRW  = NRMW + CW;         // norm times cross component
  localparam int NUMW = PRW + 2;           // numerator
  localparam int MW   = NUMW + 2;          // rounded, sign-folded dividend
  localparam int QB   = COORD_WIDTH + 1;   // quotient bits before saturation

  localparam int QUEUE_DEPTH = 4;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_COPLANAR  = 2'd1;
  localparam logic [1:0] ST_SATURATED = 2'd2;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] a_x;
    logic signed [COORD_WIDTH-1:0] a_y;
    logic signed [COORD_WIDTH-1:0] a_z;
    logic signed [COORD_WIDTH-1:0] b_x;
    logic signed [COORD_WIDTH-1:0] b_y;
    logic signed [COORD_WIDTH-1:0] b_z;
    logic signed [COORD_WIDTH-1:0] c_x;
    logic signed [COORD_WIDTH-1:0] c_y;
    logic signed [COORD_WIDTH-1:0] c_z;
    logic signed [COORD_WIDTH-1:0] d_x;
    logic signed [COORD_WIDTH-1:0] d_y;
    logic signed [COORD_WIDTH-1:0] d_z;
  } in_t;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] center_x;
    logic signed [COORD_WIDTH-1:0] center_y;
    logic signed [COORD_WIDTH-1:0] center_z;
    logic [1:0]                    status;
  } out_t;

  // classified request handed from the front to the back
  typedef struct packed {
    logic [2:0][COORD_WIDTH-1:0] p0;     // first point
    logic [2:0][2:0][CW-1:0]     cr;     // v x w, w x u, u x v
    logic [2:0][NRMW-1:0]        nrm;    // |u|^2, |v|^2, |w|^2
    logic [DW-1:0]               absd;   // |det|
    logic                        det_neg;
    logic                        coplanar;
  } front_item_t;

endpackage

`default_nettype wire

[design/tcc_mul.sv]
// pipelined signed multiplier split into limb products; limb products, row sums and the product are registered
// depends on tcc_pkg for the limb size
`timescale 1ns / 1ps
`default_nettype none

module tcc_mul #(
  parameter int AW = 33,
  parameter int BW = 67
) (
  input  logic                    clk,
  input  logic                    en,
  input  logic signed [AW-1:0]    a,
  input  logic signed [BW-1:0]    b,
  output logic signed [AW+BW-1:0] p
);
  import tcc_pkg::*;

  localparam int NA    = (AW + LIMB - 1) / LIMB;
  localparam int NB    = (BW + LIMB - 1) / LIMB;
  localparam int PRODW = AW + BW;
  localparam int PPW   = 2 * LIMB + 2;

  logic signed [LIMB:0]      al [NA];
  logic signed [LIMB:0]      bl [NB];
  logic signed [PPW-1:0]     pp [NA][NB];
  logic signed [PRODW-1:0]   rsum [NA];
  logic signed [PRODW-1:0]   row [NA];
  logic signed [PRODW-1:0]   psum;

  // lower limbs unsigned, top limb carries the sign
  always_comb begin
    for (int i = 0; i < NA; i++) begin
      if (i == NA - 1) begin
        al[i] = (LIMB+1)'(a >>> (i * LIMB));
      end else begin
        al[i] = {1'b0, a[i*LIMB +: LIMB]};
      end
    end
    for (int j = 0; j < NB; j++) begin
      if (j == NB - 1) begin
        bl[j] = (LIMB+1)'(b >>> (j * LIMB));
      end else begin
        bl[j] = {1'b0, b[j*LIMB +: LIMB]};
      end
    end
  end

  always_comb begin
    for (int i = 0; i < NA; i++) begin
      rsum[i] = '0;
      for (int j = 0; j < NB; j++) begin
        rsum[i] = rsum[i] + (PRODW'(pp[i][j]) << (j * LIMB));
      end
    end
  end

  always_comb begin
    psum = '0;
    for (int i = 0; i < NA; i++) begin
      psum = psum + (row[i] << (i * LIMB));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NA; i++) begin
        for (int j = 0; j < NB; j++) begin
          pp[i][j] <= al[i] * bl[j];
        end
        row[i] <= rsum[i];
      end
      p <= psum;
    end
  end

endmodule

`default_nettype wire

[design/tcc_div.sv]
// pipelined restoring divider, one quotient bit per stage
// depends on tcc_pkg only by convention; widths come from parameters
`timescale 1ns / 1ps
`default_nettype none

module tcc_div #(
  parameter int NW    = 139,
  parameter int DNW   = 103,
  parameter int QBITS = 33
) (
  input  logic             clk,
  input  logic             en,
  input  logic [NW-1:0]    num,
  input  logic [DNW-1:0]   den,
  output logic [QBITS-1:0] quo,
  output logic             ovf
);
  import tcc_pkg::*;

  logic [NW-1:0]    rem [QBITS];
  logic [DNW-1:0]   dv  [QBITS];
  logic [QBITS-1:0] qt  [QBITS+1];
  logic             ov  [QBITS+1];
  logic [NW-1:0]    dsh [QBITS+1];
  logic             ge  [QBITS+1];

  always_comb begin
    dsh[0] = NW'(den) << QBITS;
    ge[0]  = num >= dsh[0];
    for (int s = 1; s <= QBITS; s++) begin
      dsh[s] = NW'(dv[s-1]) << (QBITS - s);
      ge[s]  = rem[s-1] >= dsh[s];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // quotient too large for the kept bits: caller saturates
      rem[0] <= num;
      dv[0]  <= den;
      qt[0]  <= '0;
      ov[0]  <= ge[0];
      for (int s = 1; s <= QBITS; s++) begin
        // lower bits are still clear, so or in this stage's bit
        qt[s] <= qt[s-1] | (QBITS'(ge[s]) << (QBITS - s));
        ov[s] <= ov[s-1];
      end
      for (int s = 1; s < QBITS; s++) begin
        rem[s] <= ge[s] ? (rem[s-1] - dsh[s]) : rem[s-1];
        dv[s]  <= dv[s-1];
      end
    end
  end

  assign quo = qt[QBITS];
  assign ovf = ov[QBITS];

endmodule

`default_nettype wire

[design/tcc_queue.sv]
// small register queue between the front and back halves
// depends on tcc_pkg for nothing but the house import
`timescale 1ns / 1ps
`default_nettype none

module tcc_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty
);
  import tcc_pkg::*;

  localparam int PTRW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTRW-1:0]  wr_ptr;
  logic [PTRW-1:0]  rd_ptr;
  logic [CNTW-1:0]  count;
  logic             push_ok;
  logic             pop_ok;

  assign full     = (count == CNTW'(DEPTH));
  assign empty    = (count == '0);
  assign push_ok  = push && !full;
  assign pop_ok   = pop && !empty;
  assign pop_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push_ok) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push_ok) begin
        wr_ptr <= (wr_ptr == PTRW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop_ok) begin
        rd_ptr <= (rd_ptr == PTRW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + CNTW'(push_ok) - CNTW'(pop_ok);
    end
  end

endmodule

`default_nettype wire

[design/tcc_front.sv]
// front half: edge vectors, cross products, norms, orientation determinant
// and coplanar classification; uses tcc_pkg and tcc_mul
`timescale 1ns / 1ps
`default_nettype none

module tcc_front (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  tcc_pkg::in_t                        in_data,
  input  logic [tcc_pkg::THRESH_WIDTH-1:0]    thresh,
  output tcc_pkg::front_item_t                item,
  output logic                                item_valid,
  input  logic                                full
);
  import tcc_pkg::*;

  localparam int W = COORD_WIDTH;

  logic                   en;
  logic                   accept;
  logic [8:1]             vld;
  logic signed [W-1:0]    pt [4][3];
  logic signed [EW-1:0]   e [3][3];
  logic [2:0][W-1:0]      p0_s1;
  logic [2:0][W-1:0]      p0_s2;
  logic signed [PW-1:0]   pa [3][3];
  logic signed [PW-1:0]   pb [3][3];
  logic signed [PW-1:0]   sq [3][3];
  logic signed [EW-1:0]   e0_s2 [3];
  logic signed [EW-1:0]   e0_s3 [3];
  logic signed [EW+CW-1:0] dp [3];
  logic signed [DW-1:0]   det;
  logic [DW-1:0]          det_abs;
  front_item_t            it [3:8];
  front_item_t            item_next;

  assign pt[0][0] = in_data.a_x;
  assign pt[0][1] = in_data.a_y;
  assign pt[0][2] = in_data.a_z;
  assign pt[1][0] = in_data.b_x;
  assign pt[1][1] = in_data.b_y;
  assign pt[1][2] = in_data.b_z;
  assign pt[2][0] = in_data.c_x;
  assign pt[2][1] = in_data.c_y;
  assign pt[2][2] = in_data.c_z;
  assign pt[3][0] = in_data.d_x;
  assign pt[3][1] = in_data.d_y;
  assign pt[3][2] = in_data.d_z;

  // stall only when a classified request cannot enter the queue
  assign en         = !(vld[8] && full);
  assign in_stall   = !en;
  assign accept     = in_valid && en;
  assign item       = it[8];
  assign item_valid = vld[8];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[7:1], accept};
    end
  end

  // det = u . (v x w)
  for (genvar k = 0; k < 3; k++) begin : g_det
    tcc_mul #(.AW(EW), .BW(CW)) u_mul (
      .clk (clk),
      .en  (en),
      .a   (e0_s3[k]),
      .b   ($signed(it[3].cr[0][k])),
      .p   (dp[k])
    );
  end

  always_comb begin
    det_abs             = det[DW-1] ? DW'(-det) : DW'(det);
    item_next           = it[7];
    item_next.absd      = det_abs;
    item_next.det_neg   = det[DW-1];
    item_next.coplanar  = (det == '0) || (det_abs < DW'(thresh));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        for (int k = 0; k < 3; k++) begin
          e[i][k] <= EW'(pt[i+1][k]) - EW'(pt[0][k]);
        end
      end
      for (int k = 0; k < 3; k++) begin
        p0_s1[k] <= pt[0][k];
      end

      // cross c uses edges (c+1, c+2): v x w, w x u, u x v
      for (int c = 0; c < 3; c++) begin
        for (int k = 0; k < 3; k++) begin
          pa[c][k] <= e[(c+1)%3][(k+1)%3] * e[(c+2)%3][(k+2)%3];
          pb[c][k] <= e[(c+1)%3][(k+2)%3] * e[(c+2)%3][(k+1)%3];
          sq[c][k] <= e[c][k] * e[c][k];
        end
      end
      for (int k = 0; k < 3; k++) begin
        e0_s2[k] <= e[0][k];
        e0_s3[k] <= e0_s2[k];
      end
      p0_s2 <= p0_s1;

      it[3].p0       <= p0_s2;
      it[3].absd     <= '0;
      it[3].det_neg  <= 1'b0;
      it[3].coplanar <= 1'b0;
      for (int c = 0; c < 3; c++) begin
        for (int k = 0; k < 3; k++) begin
          it[3].cr[c][k] <= CW'(pa[c][k]) - CW'(pb[c][k]);
        end
        it[3].nrm[c] <= NRMW'(sq[c][0]) + NRMW'(sq[c][1]) + NRMW'(sq[c][2]);
      end

      for (int s = 4; s <= 7; s++) begin
        it[s] <= it[s-1];
      end
      det   <= DW'(dp[0]) + DW'(dp[1]) + DW'(dp[2]);
      it[8] <= item_next;
    end
  end

endmodule

`default_nettype wire

[design/tcc_back.sv]
// back half: numerators, rounded floor division by 2|det|, saturation
// uses tcc_pkg, tcc_mul and tcc_div
`timescale 1ns / 1ps
`default_nettype none

module tcc_back (
  input  logic                 clk,
  input  logic                 rst,
  input  tcc_pkg::front_item_t item,
  input  logic                 item_valid,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_stall,
  output tcc_pkg::out_t        out_data
);
  import tcc_pkg::*;

  localparam int W   = COORD_WIDTH;
  localparam int NST = QB + 8;
  localparam logic signed [W+2:0] CHI = {4'b0000, {(W-1){1'b1}}};
  localparam logic signed [W+2:0] CLO = {4'b1111, {(W-1){1'b0}}};
  localparam logic [W-1:0] SAT_HI = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] SAT_LO = {1'b1, {(W-1){1'b0}}};

  typedef struct packed {
    logic [2:0][W-1:0] p0;
    logic [DW-1:0]     absd;
    logic              det_neg;
    logic              coplanar;
  } side_t;

  typedef struct packed {
    logic [2:0][W-1:0] p0;
    logic [2:0]        qneg;
    logic              coplanar;
  } tail_t;

  logic                   en;
  logic [NST:1]           vb;
  logic signed [PRW-1:0]  prod [3][3];
  side_t                  sb [1:5];
  logic signed [NUMW-1:0] num [3];
  logic signed [MW-1:0]   np [3];
  logic [DENW-1:0]        den5;
  logic [DENW-1:0]        den6;
  logic [MW-1:0]          m6 [3];
  logic [2:0]             qneg6;
  logic [2:0][W-1:0]      p0_6;
  logic                   cop6;
  tail_t                  tl [QB+1];
  logic [QB-1:0]          qu [3];
  logic                   ovf [3];
  logic signed [QB:0]     qs [3];
  logic signed [W+2:0]    cs [3];
  logic [W-1:0]           cv [3];
  logic                   sat;
  out_t                   out_next;

  assign en        = !vb[NST] || !out_stall;
  assign pop       = en && item_valid;
  assign out_valid = vb[NST];

  always_ff @(posedge clk) begin
    if (rst) begin
      vb <= '0;
    end else if (en) begin
      vb <= {vb[NST-1:1], pop};
    end
  end

  // prod[k][t]: norm t times component k of cross t
  for (genvar k = 0; k < 3; k++) begin : g_axis
    for (genvar t = 0; t < 3; t++) begin : g_term
      tcc_mul #(.AW(NRMW), .BW(CW)) u_mul (
        .clk (clk),
        .en  (en),
        .a   ($signed(item.nrm[t])),
        .b   ($signed(item.cr[t][k])),
        .p   (prod[k][t])
      );
    end
    tcc_div #(.NW(MW), .DNW(DENW), .QBITS(QB)) u_div (
      .clk (clk),
      .en  (en),
      .num (m6[k]),
      .den (den6),
      .quo (qu[k]),
      .ovf (ovf[k])
    );
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sb[1].p0       <= item.p0;
      sb[1].absd     <= item.absd;
      sb[1].det_neg  <= item.det_neg;
      sb[1].coplanar <= item.coplanar;
      for (int s = 2; s <= 5; s++) begin
        sb[s] <= sb[s-1];
      end

      for (int k = 0; k < 3; k++) begin
        num[k] <= NUMW'(prod[k][0]) + NUMW'(prod[k][1]) + NUMW'(prod[k][2]);
        // orient by the sign of det, then add |det| for round to nearest
        np[k]  <= (sb[4].det_neg ? -MW'(num[k]) : MW'(num[k])) + MW'(sb[4].absd);
      end
      den5 <= {sb[4].absd, 1'b0};

      // floor of a negative ratio through the magnitude, rounded up
      for (int k = 0; k < 3; k++) begin
        m6[k]    <= np[k][MW-1] ? (MW'(-np[k]) + MW'(den5) - MW'(1)) : MW'(np[k]);
        qneg6[k] <= np[k][MW-1];
      end
      den6 <= den5;
      p0_6 <= sb[5].p0;
      cop6 <= sb[5].coplanar;

      tl[0].p0       <= p0_6;
      tl[0].qneg     <= qneg6;
      tl[0].coplanar <= cop6;
      for (int s = 1; s <= QB; s++) begin
        tl[s] <= tl[s-1];
      end

      out_data <= out_next;
    end
  end

  always_comb begin
    sat = 1'b0;
    for (int k = 0; k < 3; k++) begin
      qs[k] = tl[QB].qneg[k] ? -$signed({1'b0, qu[k]}) : $signed({1'b0, qu[k]});
      cs[k] = (W+3)'($signed(tl[QB].p0[k])) + (W+3)'(qs[k]);
      if (ovf[k]) begin
        cv[k] = tl[QB].qneg[k] ? SAT_LO : SAT_HI;
        sat   = 1'b1;
      end else if (cs[k] > CHI) begin
        cv[k] = SAT_HI;
        sat   = 1'b1;
      end else if (cs[k] < CLO) begin
        cv[k] = SAT_LO;
        sat   = 1'b1;
      end else begin
        cv[k] = cs[k][W-1:0];
      end
    end
    if (tl[QB].coplanar) begin
      out_next.center_x = '0;
      out_next.center_y = '0;
      out_next.center_z = '0;
      out_next.status   = ST_COPLANAR;
    end else begin
      out_next.center_x = cv[0];
      out_next.center_y = cv[1];
      out_next.center_z = cv[2];
      out_next.status   = sat ? ST_SATURATED : ST_OK;
    end
  end

endmodule

`default_nettype wire

[design/tetrahedron_circumcenter_unit.sv]
// tetrahedron circumcenter: top level, coplanar threshold register and wiring
// throughput: one request per cycle while out_stall is low, set by the fully pipelined front and back
// reset: rst synchronous, clears all valid bits and the queue, threshold to 1
// depends on tcc_pkg, tcc_front, tcc_queue, tcc_back
`timescale 1ns / 1ps
`default_nettype none

module tetrahedron_circumcenter_unit (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [tcc_pkg::THRESH_WIDTH-1:0]  cfg_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  tcc_pkg::in_t                      in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output tcc_pkg::out_t                     out_data
);
  import tcc_pkg::*;

  localparam int ITEMW = $bits(front_item_t);

  // minimum |det| (48 fraction bits) below which points count as coplanar
  logic [THRESH_WIDTH-1:0] thresh;

  // front to queue
  front_item_t f_item;
  logic        f_valid;
  logic        q_full;

  // queue to back
  logic [ITEMW-1:0] q_data;
  front_item_t      q_item;
  logic             q_empty;
  logic             b_pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      thresh <= THRESH_RESET;
    end else if (cfg_write) begin
      thresh <= cfg_data;
    end
  end

  // front: 8 stages, edges -> products -> cross/norm -> det -> classify;
  // it stalls only when the queue is full, so the input stall comes from registers only
  tcc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .thresh     (thresh),
    .item       (f_item),
    .item_valid (f_valid),
    .full       (q_full)
  );

  // short queue decouples the two halves so each stalls on its own
  tcc_queue #(.WIDTH(ITEMW), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (f_valid),
    .push_data (f_item),
    .full      (q_full),
    .pop       (b_pop),
    .pop_data  (q_data),
    .empty     (q_empty)
  );

  assign q_item = q_data;

  // back: numerators, one quotient bit per stage, then add point a and clamp;
  // its last stage is the output register
  tcc_back u_back (
    .clk        (clk),
    .rst        (rst),
    .item       (q_item),
    .item_valid (!q_empty),
    .pop        (b_pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

endmodule

`default_nettype wire

[sim/tcc_checker.sv]
// tetrahedron circumcenter checker: watches both channels and the threshold port,
// predicts each center with exact wide arithmetic and compares; depends on tcc_pkg
`timescale 1ns / 1ps
`default_nettype none

module tcc_checker (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [tcc_pkg::THRESH_WIDTH-1:0]  cfg_data,
  input  logic                              in_valid,
  input  logic                              in_stall,
  input  tcc_pkg::in_t                      in_data,
  input  logic                              out_valid,
  input  logic                              out_stall,
  input  tcc_pkg::out_t                     out_data,
  output int                                failures,
  output int                                pending
);
  import tcc_pkg::*;

  typedef logic signed [255:0] wide_t;

  logic [THRESH_WIDTH-1:0] thresh;
  out_t centers_due[$];

  function automatic out_t circumcenter_of(in_t r, logic [THRESH_WIDTH-1:0] thr);
    wide_t p [4][3];
    wide_t e [3][3];
    wide_t vw [3];
    wide_t wu [3];
    wide_t uv [3];
    wide_t det, absd, den, nu, nv, nw, num, t, q, c, hi, lo;
    out_t o;
    p[0][0] = r.a_x; p[0][1] = r.a_y; p[0][2] = r.a_z;
    p[1][0] = r.b_x; p[1][1] = r.b_y; p[1][2] = r.b_z;
    p[2][0] = r.c_x; p[2][1] = r.c_y; p[2][2] = r.c_z;
    p[3][0] = r.d_x; p[3][1] = r.d_y; p[3][2] = r.d_z;
    for (int i = 0; i < 3; i++)
      for (int k = 0; k < 3; k++)
        e[i][k] = p[i+1][k] - p[0][k];
    vw[0] = e[1][1]*e[2][2] - e[1][2]*e[2][1];
    vw[1] = e[1][2]*e[2][0] - e[1][0]*e[2][2];
    vw[2] = e[1][0]*e[2][1] - e[1][1]*e[2][0];
    wu[0] = e[2][1]*e[0][2] - e[2][2]*e[0][1];
    wu[1] = e[2][2]*e[0][0] - e[2][0]*e[0][2];
    wu[2] = e[2][0]*e[0][1] - e[2][1]*e[0][0];
    uv[0] = e[0][1]*e[1][2] - e[0][2]*e[1][1];
    uv[1] = e[0][2]*e[1][0] - e[0][0]*e[1][2];
    uv[2] = e[0][0]*e[1][1] - e[0][1]*e[1][0];
    det  = e[0][0]*vw[0] + e[0][1]*vw[1] + e[0][2]*vw[2];
    absd = (det < 0) ? -det : det;
    o = '0;
    if (det == 0 || absd < $signed({207'b0, thr})) begin
      o.status = ST_COPLANAR;
      return o;
    end
    o.status = ST_OK;
    nu  = e[0][0]*e[0][0] + e[0][1]*e[0][1] + e[0][2]*e[0][2];
    nv  = e[1][0]*e[1][0] + e[1][1]*e[1][1] + e[1][2]*e[1][2];
    nw  = e[2][0]*e[2][0] + e[2][1]*e[2][1] + e[2][2]*e[2][2];
    den = absd + absd;
    hi  = 2147483647;
    lo  = -hi - 1;
    for (int k = 0; k < 3; k++) begin
      num = nu*vw[k] + nv*wu[k] + nw*uv[k];
      if (det < 0) num = -num;
      // round to nearest, ties up: floor((num + |det|) / (2 |det|))
      t = num + absd;
      q = t / den;
      if (t < 0 && q*den != t) q = q - 1;
      c = p[0][k] + q;
      if (c > hi) begin
        c = hi; o.status = ST_SATURATED;
      end else if (c < lo) begin
        c = lo; o.status = ST_SATURATED;
      end
      case (k)
        0: o.center_x = c[31:0];
        1: o.center_y = c[31:0];
        default: o.center_z = c[31:0];
      endcase
    end
    return o;
  endfunction

  always @(posedge clk) begin
    out_t want;
    if (rst) begin
      thresh <= THRESH_RESET;
      centers_due.delete();
      failures <= 0;
      pending  <= 0;
    end else begin
      if (cfg_write) thresh <= cfg_data;
      if (in_valid && !in_stall) centers_due.push_back(circumcenter_of(in_data, thresh));
      if (out_valid && !out_stall) begin
        if (centers_due.size() == 0) begin
          if (failures < 10) $display("checker: unexpected result %p", out_data);
          failures <= failures + 1;
        end else begin
          want = centers_due.pop_front();
          if (want !== out_data) begin
            if (failures < 10)
              $display("checker: mismatch expected %p got %p", want, out_data);
            failures <= failures + 1;
          end
        end
      end
      pending <= centers_due.size();
    end
  end

endmodule

`default_nettype wire

[sim/tb.sv]
// tetrahedron circumcenter testbench top: clock, reset, request stimulus and verdict
// depends on tcc_pkg, tetrahedron_circumcenter_unit and tcc_checker
`timescale 1ns / 1ps
`default_nettype none

module tb;
  import tcc_pkg::*;

  localparam int LATENCY = 50;
  localparam logic [THRESH_WIDTH-1:0] THRESH_MAX = 49'h1_0000_0000_0000;

  logic clk = 0;
  logic rst = 1;
  logic cfg_write = 0;
  logic [THRESH_WIDTH-1:0] cfg_data = '0;
  logic in_valid = 0;
  logic in_stall;
  in_t  in_data = '0;
  logic out_valid;
  logic out_stall = 0;
  out_t out_data;
  int   failures, pending;

  // no idling on either side once set, used for the last stretch
  bit calm = 0;
  int stall_left = 0;

  always #5 clk = ~clk;

  tetrahedron_circumcenter_unit dut (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  tcc_checker chk (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .failures(failures), .pending(pending)
  );

  // receiver: random bursts of stall or no stall, each burst stalling with one chance in three
  always @(posedge clk) begin
    if (calm) begin
      out_stall <= 0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else begin
      out_stall  <= ($urandom_range(0, 2) == 0);
      stall_left <= $urandom_range(1, 17);
    end
  end

  // present one request and hold it until it is taken
  task automatic send_points(in_t pts);
    logic stl;
    in_data  <= pts;
    in_valid <= 1;
    do begin
      @(negedge clk);
      stl = in_stall;
      @(posedge clk);
    end while (stl);
    // occasional sender gap
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
  endtask

  // drain everything, let the pipe empty, then write the threshold
  task automatic set_threshold(logic [THRESH_WIDTH-1:0] thr);
    in_valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    cfg_write <= 1;
    cfg_data  <= thr;
    @(posedge clk);
    cfg_write <= 0;
  endtask

  function automatic logic [31:0] small_coord();
    return $signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
  endfunction

  function automatic logic [31:0] edge_coord();
    case ($urandom_range(0, 4))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'h0000_0000;
      3: return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  // random tetrahedron, mostly well formed with some degenerate shapes
  function automatic in_t random_points();
    in_t r;
    int mode;
    mode = $urandom_range(0, 9);
    for (int i = 0; i < 12; i++)
      r[i*32 +: 32] = (mode <= 3) ? small_coord() :
                      (mode == 8) ? edge_coord() : $urandom;
    case (mode)
      6: begin  // coplanar: d = b + c - a
        r.d_x = r.b_x + r.c_x - r.a_x;
        r.d_y = r.b_y + r.c_y - r.a_y;
        r.d_z = r.b_z + r.c_z - r.a_z;
      end
      7: begin  // nearly flat, center flies far away
        r.b_z = r.a_z + $urandom_range(0, 3);
        r.c_z = r.a_z + $urandom_range(0, 3);
        r.d_z = r.a_z + $urandom_range(0, 3);
      end
      9: r.d_x = r.b_x;  // shared coordinate, sometimes a repeated point
      default: ;
    endcase
    if (mode == 9 && $urandom_range(0, 1) == 1) begin
      r.d_y = r.b_y; r.d_z = r.b_z;
    end
    return r;
  endfunction

  function automatic in_t make_pts(int ax, int ay, int az, int bx, int by, int bz,
                                   int cx, int cy, int cz, int dx, int dy, int dz);
    in_t r;
    r.a_x = ax; r.a_y = ay; r.a_z = az;
    r.b_x = bx; r.b_y = by; r.b_z = bz;
    r.c_x = cx; r.c_y = cy; r.c_z = cz;
    r.d_x = dx; r.d_y = dy; r.d_z = dz;
    return r;
  endfunction

  initial begin
    in_t r;
    repeat (7) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: unit corner tetrahedron, both orientations, scaled
    send_points(make_pts(0, 0, 0, 65536, 0, 0, 0, 65536, 0, 0, 0, 65536));
    send_points(make_pts(0, 0, 0, 0, 65536, 0, 65536, 0, 0, 0, 0, 65536));
    send_points(make_pts(-65536, -65536, -65536, 1 << 30, 0, 0, 0, 1 << 30, 0,
                         0, 0, 1 << 30));
    // all points equal: zero determinant
    send_points('0);
    // coplanar square
    send_points(make_pts(0, 0, 0, 65536, 0, 0, 0, 65536, 0, 65536, 65536, 0));
    // smallest nonzero determinant, right at the reset threshold
    send_points(make_pts(0, 0, 0, 1, 0, 0, 0, 1, 0, 0, 0, 1));
    // extremes of the coordinate range
    send_points(make_pts(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                         32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000,
                         32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
                         32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff));
    send_points(make_pts(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                         32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff,
                         32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
                         32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000));
    // thin sliver: center saturates high and low
    send_points(make_pts(0, 0, 0, 1 << 30, 0, 0, 0, 1 << 30, 0, 1 << 29, 1 << 29, 1));
    send_points(make_pts(0, 0, 0, 1 << 30, 0, 0, 0, 1 << 30, 0, 1 << 29, 1 << 29, -1));
    send_points(make_pts(0, 0, 0, -(1 << 30), 0, 0, 0, -(1 << 30), 0,
                         -(1 << 29), -(1 << 29), 1));
    repeat (8) begin
      for (int i = 0; i < 12; i++) r[i*32 +: 32] = edge_coord();
      send_points(r);
    end

    repeat (300) send_points(random_points());

    // sender holds off until every result is back
    in_valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (50) send_points(random_points());

    set_threshold('0);
    repeat (200) send_points(random_points());
    set_threshold(THRESH_MAX);
    repeat (200) send_points(random_points());
    set_threshold(THRESH_WIDTH'({16'($urandom_range(0, 16'h7fff)), $urandom, 1'b1}));
    repeat (200) send_points(random_points());
    set_threshold(THRESH_RESET);
    calm = 1;
    repeat (250) send_points(random_points());

    in_valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (LATENCY + 20) @(posedge clk);
    if (failures == 0)
      $display("tb: clean");
    else
      $display("tb: errors");
    $finish;
  end

  initial begin
    #20ms;
    $display("tb: errors");
    $finish;
  end

endmodule

`default_nettype wire
